// File: rtl/core/assert_macros.svh
// assertion macros used by point_to_segment_projection
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: rtl/core/ptsp_pkg.sv
// shared types and case codes for the segment projection pipeline
// no dependencies
package ptsp_pkg;
	typedef enum logic [1:0] {
		CASE_INTERIOR  = 2'd0,
		CASE_START     = 2'd1,
		CASE_END       = 2'd2,
		CASE_DEGENERATE = 2'd3
	} case_code_t;

	localparam int unsigned CFG_IDX_WIDTH = 2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_START_X = 2'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_START_Y = 2'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_END_X   = 2'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_END_Y   = 2'd3;

	// pipeline stage control: valid and advance flags
	typedef struct packed {
		logic valid;
		logic advance;
	} stage_ctl_t;
endpackage

// File: rtl/core/ptsp_front.sv
// front stages: differences, products, dot product and squared length
// depends on ptsp_pkg
module ptsp_front #(
	parameter int unsigned CW = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  in_valid,
	input  logic signed [CW-1:0]  px,
	input  logic signed [CW-1:0]  py,
	input  logic signed [CW-1:0]  sx,
	input  logic signed [CW-1:0]  sy,
	input  logic signed [CW-1:0]  ex,
	input  logic signed [CW-1:0]  ey,
	output logic                  valid_s3,
	output logic [2*CW+1:0]       smag_s3,
	output logic                  sneg_s3,
	output logic [2*CW+1:0]       len2_s3,
	output logic [CW:0]           umx_s3,
	output logic [CW:0]           umy_s3,
	output logic                  uxn_s3,
	output logic                  uyn_s3,
	output logic signed [CW-1:0]  px_s3,
	output logic signed [CW-1:0]  py_s3,
	output logic signed [CW-1:0]  sx_s3,
	output logic signed [CW-1:0]  sy_s3,
	output logic signed [CW-1:0]  ex_s3,
	output logic signed [CW-1:0]  ey_s3
);
	import ptsp_pkg::*;
	localparam int unsigned DW = CW + 1;
	localparam int unsigned PW = 2 * DW;

	logic signed [DW-1:0] ux, uy, ax, ay;
	logic                 valid_s1, valid_s2;
	logic signed [DW-1:0] ux_s1, uy_s1, ax_s1, ay_s1;
	logic signed [CW-1:0] px_s1, py_s1, sx_s1, sy_s1, ex_s1, ey_s1;
	logic signed [PW-1:0] tx_s2, ty_s2, lx_s2, ly_s2;
	logic signed [DW-1:0] ux_s2, uy_s2;
	logic signed [CW-1:0] px_s2, py_s2, sx_s2, sy_s2, ex_s2, ey_s2;
	logic signed [PW:0]   dot, len;

	assign ux = DW'(ex) - DW'(sx);
	assign uy = DW'(ey) - DW'(sy);
	assign ax = DW'(px) - DW'(sx);
	assign ay = DW'(py) - DW'(sy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ux_s1 <= ux; uy_s1 <= uy; ax_s1 <= ax; ay_s1 <= ay;
			px_s1 <= px; py_s1 <= py; sx_s1 <= sx; sy_s1 <= sy;
			ex_s1 <= ex; ey_s1 <= ey;
			tx_s2 <= ax_s1 * ux_s1;
			ty_s2 <= ay_s1 * uy_s1;
			lx_s2 <= ux_s1 * ux_s1;
			ly_s2 <= uy_s1 * uy_s1;
			ux_s2 <= ux_s1; uy_s2 <= uy_s1;
			px_s2 <= px_s1; py_s2 <= py_s1; sx_s2 <= sx_s1; sy_s2 <= sy_s1;
			ex_s2 <= ex_s1; ey_s2 <= ey_s1;
			smag_s3 <= dot[PW] ? (PW'(0) - dot[PW-1:0]) : dot[PW-1:0];
			sneg_s3 <= dot[PW];
			len2_s3 <= len[PW-1:0];
			umx_s3  <= ux_s2[DW-1] ? DW'(-ux_s2) : DW'(ux_s2);
			umy_s3  <= uy_s2[DW-1] ? DW'(-uy_s2) : DW'(uy_s2);
			uxn_s3  <= ux_s2[DW-1];
			uyn_s3  <= uy_s2[DW-1];
			px_s3 <= px_s2; py_s3 <= py_s2; sx_s3 <= sx_s2; sy_s3 <= sy_s2;
			ex_s3 <= ex_s2; ey_s3 <= ey_s2;
		end
	end

	// dot and length have one extra bit so the sums never wrap
	assign dot = (PW+1)'(tx_s2) + (PW+1)'(ty_s2);
	assign len = (PW+1)'(lx_s2) + (PW+1)'(ly_s2);
endmodule

// File: rtl/core/ptsp_div.sv
// pipelined restoring divider, one quotient bit per stage, two lanes
// depends on ptsp_pkg
module ptsp_div #(
	parameter int unsigned NW = 76,
	parameter int unsigned DW = 50,
	parameter int unsigned QW = 25,
	parameter int unsigned SW = 50
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          in_valid,
	input  logic [NW-1:0] num_x,
	input  logic [NW-1:0] num_y,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side,
	output logic          out_valid,
	output logic [QW-1:0] quo_x,
	output logic [QW-1:0] quo_y,
	output logic [SW-1:0] side_out
);
	import ptsp_pkg::*;
	// quotient fits QW bits since s <= len, so numerator < den << QW
	localparam int unsigned RW = DW + 1;

	logic          v_q [QW+1];
	logic [NW-1:0] nx_q [QW+1];
	logic [NW-1:0] ny_q [QW+1];
	logic [RW-1:0] rx_q [QW+1];
	logic [RW-1:0] ry_q [QW+1];
	logic [QW-1:0] qx_q [QW+1];
	logic [QW-1:0] qy_q [QW+1];
	logic [DW-1:0] d_q  [QW+1];
	logic [SW-1:0] sd_q [QW+1];

	always_comb begin
		v_q[0] = in_valid; nx_q[0] = num_x; ny_q[0] = num_y;
		rx_q[0] = RW'(num_x >> QW); ry_q[0] = RW'(num_y >> QW);
		qx_q[0] = '0; qy_q[0] = '0; d_q[0] = den; sd_q[0] = side;
	end

	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int unsigned B = QW - 1 - k;
		logic [RW-1:0] tx, ty;
		logic          v_r;
		logic [NW-1:0] nx_r, ny_r;
		logic [RW-1:0] rx_r, ry_r;
		logic [QW-1:0] qx_r, qy_r;
		logic [DW-1:0] d_r;
		logic [SW-1:0] sd_r;
		assign tx = {rx_q[k][RW-2:0], nx_q[k][B]};
		assign ty = {ry_q[k][RW-2:0], ny_q[k][B]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_r <= 1'b0;
			else if (adv) v_r <= v_q[k];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				nx_r <= nx_q[k]; ny_r <= ny_q[k]; d_r <= d_q[k]; sd_r <= sd_q[k];
				if (tx >= RW'(d_q[k])) begin
					rx_r <= tx - RW'(d_q[k]); qx_r <= qx_q[k] | (QW'(1) << B);
				end else begin
					rx_r <= tx; qx_r <= qx_q[k];
				end
				if (ty >= RW'(d_q[k])) begin
					ry_r <= ty - RW'(d_q[k]); qy_r <= qy_q[k] | (QW'(1) << B);
				end else begin
					ry_r <= ty; qy_r <= qy_q[k];
				end
			end
		end
		always_comb begin
			v_q[k+1] = v_r; nx_q[k+1] = nx_r; ny_q[k+1] = ny_r;
			rx_q[k+1] = rx_r; ry_q[k+1] = ry_r; qx_q[k+1] = qx_r;
			qy_q[k+1] = qy_r; d_q[k+1] = d_r; sd_q[k+1] = sd_r;
		end
	end

	assign out_valid = v_q[QW];
	assign quo_x = qx_q[QW];
	assign quo_y = qy_q[QW];
	assign side_out = sd_q[QW];
endmodule

// File: rtl/core/point_to_segment_projection.sv
// channel   dir  fields (low bit first)            accept
// s_axis    in   point_x, point_y                   s_axis_tvalid & s_axis_tready
// m_axis    out  proj_x, proj_y, case_code           m_axis_tvalid & m_axis_tready
// cfg       in   index, data (start_x..end_y)        cfg_valid & cfg_ready
// one request per cycle sustained, through a bit-per-stage divider; the whole
// pipe freezes while the output register is full and not taken; arst_n clears
// valid bits and the config registers
// depends on ptsp_pkg, ptsp_front, ptsp_div, assert_macros.svh
module point_to_segment_projection #(
	parameter int unsigned COORD_WIDTH = 24,
	parameter int unsigned FRAC_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// point_x, point_y
	input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// proj_x, proj_y, case_code
	output logic [((2*COORD_WIDTH+2+7)/8)*8-1:0] m_axis_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [ptsp_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [COORD_WIDTH-1:0] cfg_data
);
	import ptsp_pkg::*;
	`include "assert_macros.svh"
	localparam int unsigned CW = COORD_WIDTH;
	localparam int unsigned DW = CW + 1;
	localparam int unsigned LW = 2 * DW;
	localparam int unsigned NW = LW + DW;
	localparam int unsigned SW = 4 * CW + 4;
	localparam int unsigned OW = ((2*CW+2+7)/8)*8;
	// fractional bits never enter the arithmetic, the ratio has no unit
	localparam int unsigned FRAC_UNUSED = FRAC_BITS;

	logic signed [CW-1:0] sx_q, sy_q, ex_q, ey_q;
	logic adv, ovalid_q;
	stage_ctl_t ctl;
	logic [OW-1:0] odata_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q <= '0; sy_q <= '0; ex_q <= '0; ey_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_START_X: sx_q <= cfg_data;
				REG_START_Y: sy_q <= cfg_data;
				REG_END_X:   ex_q <= cfg_data;
				REG_END_Y:   ey_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv = !ovalid_q || m_axis_tready;
	assign s_axis_tready = adv;

	logic v3, sneg3, uxn3, uyn3;
	logic [LW-1:0] smag3, len3;
	logic [DW-1:0] umx3, umy3;
	logic signed [CW-1:0] px3, py3, sx3, sy3, ex3, ey3;

	ptsp_front #(.CW(CW)) u_front (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(s_axis_tvalid),
		.px(s_axis_tdata[CW-1:0]), .py(s_axis_tdata[2*CW-1:CW]),
		.sx(sx_q), .sy(sy_q), .ex(ex_q), .ey(ey_q),
		.valid_s3(v3), .smag_s3(smag3), .sneg_s3(sneg3), .len2_s3(len3),
		.umx_s3(umx3), .umy_s3(umy3), .uxn_s3(uxn3), .uyn_s3(uyn3),
		.px_s3(px3), .py_s3(py3), .sx_s3(sx3), .sy_s3(sy3), .ex_s3(ex3), .ey_s3(ey3)
	);

	// stage 4: classify and form the half-width partial products
	logic v4; case_code_t code4;
	logic uxn4, uyn4;
	logic [LW-1:0] pxl4, pxh4, pyl4, pyh4;
	logic [LW-1:0] len4;
	logic signed [CW-1:0] rx4, ry4, sx4, sy4;
	case_code_t code_c;
	logic signed [CW-1:0] rx_c, ry_c;
	always_comb begin
		code_c = CASE_INTERIOR; rx_c = sx3; ry_c = sy3;
		if (len3 == '0) begin
			code_c = CASE_DEGENERATE; rx_c = px3; ry_c = py3;
		end else if (sneg3) begin
			code_c = CASE_START;
		end else if (smag3 > len3) begin
			code_c = CASE_END; rx_c = ex3; ry_c = ey3;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v4 <= 1'b0;
		else if (adv) v4 <= v3;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			code4 <= code_c; rx4 <= rx_c; ry4 <= ry_c; sx4 <= sx3; sy4 <= sy3;
			uxn4 <= uxn3; uyn4 <= uyn3; len4 <= len3;
			pxl4 <= LW'(smag3[DW-1:0]) * LW'(umx3);
			pxh4 <= LW'(smag3[LW-1:DW]) * LW'(umx3);
			pyl4 <= LW'(smag3[DW-1:0]) * LW'(umy3);
			pyh4 <= LW'(smag3[LW-1:DW]) * LW'(umy3);
		end
	end

	// stage 5: sum partial products into the numerators
	logic v5; case_code_t code5;
	logic uxn5, uyn5;
	logic [NW-1:0] numx5, numy5;
	logic [LW-1:0] len5;
	logic signed [CW-1:0] rx5, ry5, sx5, sy5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v5 <= 1'b0;
		else if (adv) v5 <= v4;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			code5 <= code4; rx5 <= rx4; ry5 <= ry4; sx5 <= sx4; sy5 <= sy4;
			uxn5 <= uxn4; uyn5 <= uyn4; len5 <= len4;
			// interior only needs smag <= len; others are zeroed to stay in range
			numx5 <= (code4 == CASE_INTERIOR) ? NW'(pxl4) + {pxh4, DW'(0)} : '0;
			numy5 <= (code4 == CASE_INTERIOR) ? NW'(pyl4) + {pyh4, DW'(0)} : '0;
		end
	end

	logic vd;
	logic [DW-1:0] qx, qy;
	logic [SW-1:0] sd;
	ptsp_div #(.NW(NW), .DW(LW), .QW(DW), .SW(SW)) u_div (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(v5),
		.num_x(numx5), .num_y(numy5),
		.den((code5 == CASE_INTERIOR) ? len5 : LW'(1)),
		.side({code5, uxn5, uyn5, rx5, ry5, sx5, sy5}),
		.out_valid(vd), .quo_x(qx), .quo_y(qy), .side_out(sd)
	);

	case_code_t coded;
	logic uxnd, uynd;
	logic signed [CW-1:0] rxd, ryd, sxd, syd, fx, fy;
	assign {coded, uxnd, uynd, rxd, ryd, sxd, syd} = sd;
	always_comb begin
		fx = rxd; fy = ryd;
		if (coded == CASE_INTERIOR) begin
			fx = uxnd ? sxd - CW'(qx) : sxd + CW'(qx);
			fy = uynd ? syd - CW'(qy) : syd + CW'(qy);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovalid_q <= 1'b0;
		else if (adv) ovalid_q <= vd;
	end
	always_ff @(posedge clk) begin
		if (adv) odata_q <= OW'({coded, fy, fx}) | OW'(FRAC_UNUSED & 0);
	end
	assign ctl = '{valid: ovalid_q, advance: adv};
	assign m_axis_tvalid = ctl.valid;
	assign m_axis_tdata = odata_q;

	`ASSERT_IMPL(a_stall_hold, clk, arst_n, ovalid_q && !m_axis_tready, !ctl.advance, "pipe moved under stall")
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed under stall")
	`ASSERT_IMPL(a_degen_code, clk, arst_n, v3 && len3 == '0, code_c == CASE_DEGENERATE, "zero length not flagged")
endmodule
